/* src/vdl_pkg.sv */
// ----------------------------------------------------------------------------
// vdl_pkg
// Types and constants shared by the vertex duplicate lookup unit and its
// checker.
// ----------------------------------------------------------------------------
package vdl_pkg;

  localparam int FIELD_BITS = 32;
  localparam int ID_BITS    = 16;
  localparam int NUM_ATTR   = 8;
  localparam int STRIDE_W   = 4;
  localparam int TOL_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_LAYOUT_STRIDE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_TOL     = 1'b1;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 4'd8;
  localparam logic [TOL_W-1:0]    TOL_RESET      = 20'd11;
  localparam logic [STRIDE_W-1:0] STRIDE_TEX_ONLY = 4'd5;
  localparam logic [STRIDE_W-1:0] STRIDE_PNT     = 4'd8;
  localparam logic [STRIDE_W-1:0] STRIDE_FULL    = 4'd14;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_HIT      = 2'd2,
    STAT_MISS     = 2'd3
  } status_t;

  typedef struct packed {
    logic                         req_type;
    logic [ID_BITS-1:0]           vertex_index;
    logic signed [FIELD_BITS-1:0] pos_x;
    logic signed [FIELD_BITS-1:0] pos_y;
    logic signed [FIELD_BITS-1:0] pos_z;
    logic signed [FIELD_BITS-1:0] nrm_x;
    logic signed [FIELD_BITS-1:0] nrm_y;
    logic signed [FIELD_BITS-1:0] nrm_z;
    logic signed [FIELD_BITS-1:0] tex_u;
    logic signed [FIELD_BITS-1:0] tex_v;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ID_BITS-1:0] match_index;
  } rsp_t;

  // Lanes: 0..2 position, 3..5 normal, 6..7 texture coordinate
  function automatic logic [NUM_ATTR-1:0] attr_mask(input logic [STRIDE_W-1:0] stride);
    logic use_nrm;
    logic use_tex;
    use_nrm = stride > STRIDE_TEX_ONLY;
    use_tex = (stride == STRIDE_TEX_ONLY) || (stride == STRIDE_PNT) ||
              (stride == STRIDE_FULL);
    return {use_tex, use_tex, use_nrm, use_nrm, use_nrm, 3'b111};
  endfunction

endpackage

/* src/vertex_duplicate_lookup_unit.sv */
// Flow: insert and empty-table query go from ST_IDLE through ST_FINISH to
//   out_valid; a query scans entries in order, stopping at the first hit.
// Throughput: one transaction at a time; a full 1024-entry scan is paced by
//   the single entry comparator reading one table row a cycle.
// Reset: synchronous, clears the entry count and registers; table contents
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// vertex_duplicate_lookup_unit
// Vertex table with insert and tolerance-matched first-hit lookup, scanning
// the entry memory through one shared comparator under a small sequencer.
// ----------------------------------------------------------------------------
module vertex_duplicate_lookup_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  vdl_pkg::req_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vdl_pkg::rsp_t               out_data,
  input  logic                        cfg_we,
  input  logic [vdl_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [vdl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vdl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = (COORD_BITS + 2 > TOL_W + 2) ? COORD_BITS + 2 : TOL_W + 2;

  typedef logic [NUM_ATTR-1:0][COORD_BITS-1:0] attr_vec_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    attr_vec_t          attr;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [STRIDE_W-1:0]    layout_stride;
  logic [TOL_W-1:0]       match_tolerance;
  logic [CW-1:0]          entry_count;
  logic [CW-1:0]          issue_cnt;
  attr_vec_t              q_attr;
  logic [NUM_ATTR-1:0]    q_mask;
  logic                   rd_valid;
  logic                   rd_last_q;
  logic                   cmp_valid;
  logic                   cmp_hit;
  logic                   cmp_last;
  logic [ID_BITS-1:0]     cmp_id;
  status_t                res_status;
  logic [ID_BITS-1:0]     res_index;

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_data;
  entry_t                 wr_data;
  attr_vec_t              in_attr;

  logic                   in_fire;
  logic                   table_full;
  logic                   wr_en;
  logic                   stop;
  logic                   rd_en;
  logic                   rd_last;
  logic signed [DW-1:0]   tol_ext;
  logic signed [DW-1:0]   diff [NUM_ATTR];
  logic [NUM_ATTR-1:0]    lane_ok;
  logic                   entry_hit;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign table_full = (entry_count == CW'(TABLE_DEPTH));
  assign wr_en      = in_fire && (in_data.req_type == REQ_INSERT) && !table_full;

  assign in_attr[0] = in_data.pos_x[COORD_BITS-1:0];
  assign in_attr[1] = in_data.pos_y[COORD_BITS-1:0];
  assign in_attr[2] = in_data.pos_z[COORD_BITS-1:0];
  assign in_attr[3] = in_data.nrm_x[COORD_BITS-1:0];
  assign in_attr[4] = in_data.nrm_y[COORD_BITS-1:0];
  assign in_attr[5] = in_data.nrm_z[COORD_BITS-1:0];
  assign in_attr[6] = in_data.tex_u[COORD_BITS-1:0];
  assign in_attr[7] = in_data.tex_v[COORD_BITS-1:0];

  assign wr_data.id   = in_data.vertex_index;
  assign wr_data.attr = in_attr;

  assign stop    = cmp_valid && (cmp_hit || cmp_last);
  assign rd_en   = (state == ST_SCAN) && (issue_cnt != entry_count) && !stop;
  assign rd_last = (CW'(issue_cnt + 1'b1) == entry_count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[entry_count[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[issue_cnt[AW-1:0]];
    end
  end

  // Shared entry comparator
  assign tol_ext = DW'(match_tolerance);

  always_comb begin
    for (int k = 0; k < NUM_ATTR; k++) begin
      diff[k]    = DW'(signed'(rd_data.attr[k])) - DW'(signed'(q_attr[k]));
      lane_ok[k] = (diff[k] <= tol_ext) && (-diff[k] <= tol_ext);
    end
    entry_hit = &(lane_ok | ~q_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      layout_stride   <= STRIDE_RESET;
      match_tolerance <= TOL_RESET;
      entry_count     <= '0;
      out_valid       <= 1'b0;
      rd_valid        <= 1'b0;
      cmp_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LAYOUT_STRIDE: layout_stride   <= cfg_data[STRIDE_W-1:0];
          REG_MATCH_TOL:     match_tolerance <= cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      // reads still in flight behind a stop are dropped
      rd_valid  <= rd_en;
      rd_last_q <= rd_last;
      cmp_valid <= rd_valid && !stop;
      cmp_hit   <= entry_hit;
      cmp_last  <= rd_last_q;
      cmp_id    <= rd_data.id;

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            res_index <= '0;
            if (in_data.req_type == REQ_INSERT) begin
              res_status <= table_full ? STAT_FULL : STAT_INSERTED;
              if (!table_full) begin
                entry_count <= CW'(entry_count + 1'b1);
              end
              state <= ST_FINISH;
            end else begin
              q_attr    <= in_attr;
              q_mask    <= attr_mask(layout_stride);
              issue_cnt <= '0;
              if (entry_count == '0) begin
                res_status <= STAT_MISS;
                state      <= ST_FINISH;
              end else begin
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_cnt <= CW'(issue_cnt + 1'b1);
          end
          if (stop) begin
            res_status <= cmp_hit ? STAT_HIT : STAT_MISS;
            res_index  <= cmp_hit ? cmp_id : '0;
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.status      <= res_status;
            out_data.match_index <= res_index;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/vdl_checker.sv */
// ----------------------------------------------------------------------------
// vdl_checker
// Port-level checks for the vertex duplicate lookup unit, bound to the top.
// ----------------------------------------------------------------------------
module vdl_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input vdl_pkg::req_t in_data,
  input logic          out_valid,
  input logic          out_ready,
  input vdl_pkg::rsp_t out_data
);
  import vdl_pkg::*;

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // One transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("unit not idle after reset");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STAT_HIT) |-> out_data.match_index == '0)
    else $error("non-zero index on a result other than a hit");

endmodule

bind vertex_duplicate_lookup_unit vdl_checker u_vdl_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex duplicate lookup unit. A queue of
// inserts and tolerance queries feeds a valid/ready driver, and a shadow
// vertex table predicts the status and first-hit index of every transaction.
// Phases sweep the layout stride and the tolerance, and add random
// handshake gaps and one long output stall. The last phases run back to
// back at the widest stride, and then with random gaps at stride fifteen.
// ----------------------------------------------------------------------------
module tb_top;
  import vdl_pkg::*;

  localparam int TBL_DEPTH   = 1024;
  localparam int CLK_HALF    = 6;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 40;
  localparam longint TOL_PICK = 64'hFFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  req_t                  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = REG_LAYOUT_STRIDE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  req_t pending_reqs[$];
  req_t made_vertices[$];
  rsp_t expected_rsp[$];

  req_t               vtx_table[TBL_DEPTH];
  int unsigned        vtx_count = 0;
  logic [STRIDE_W-1:0] model_stride = STRIDE_RESET;
  logic [TOL_W-1:0]    model_tol = TOL_RESET;

  int unsigned send_idle_max = 15;
  int unsigned recv_idle_max = 15;
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned fault_count = 0;
  int unsigned results_seen = 0;

  vertex_duplicate_lookup_unit #(
    .TABLE_DEPTH (TBL_DEPTH),
    .COORD_BITS  (FIELD_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic bit attr_close(int a, int b);
    longint diff;
    diff = longint'(a) - longint'(b);
    if (diff < 0) diff = -diff;
    return diff <= longint'(model_tol);
  endfunction

  function automatic rsp_t lookup_vertex(req_t r);
    rsp_t res;
    req_t ent;
    bit   use_nrm;
    bit   use_tex;
    bit   hit;
    res.status = STAT_MISS;
    res.match_index = '0;
    if (r.req_type == REQ_INSERT) begin
      if (vtx_count >= TBL_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        vtx_table[vtx_count] = r;
        vtx_count++;
        res.status = STAT_INSERTED;
      end
      return res;
    end
    use_nrm = model_stride > STRIDE_TEX_ONLY;
    use_tex = (model_stride == STRIDE_TEX_ONLY) || (model_stride == STRIDE_PNT) ||
              (model_stride == STRIDE_FULL);
    for (int i = 0; i < vtx_count; i++) begin
      ent = vtx_table[i];
      hit = attr_close(ent.pos_x, r.pos_x) && attr_close(ent.pos_y, r.pos_y) &&
            attr_close(ent.pos_z, r.pos_z);
      if (use_nrm)
        hit = hit && attr_close(ent.nrm_x, r.nrm_x) && attr_close(ent.nrm_y, r.nrm_y) &&
              attr_close(ent.nrm_z, r.nrm_z);
      if (use_tex)
        hit = hit && attr_close(ent.tex_u, r.tex_u) && attr_close(ent.tex_v, r.tex_v);
      if (hit) begin
        res.status = STAT_HIT;
        res.match_index = ent.vertex_index;
        return res;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [FIELD_BITS-1:0] rand_coord();
    int c;
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: begin
        // clustered around -1.0, 0.0 and 1.0
        c = (int'($urandom_range(0, 2)) - 1) * 1048576 + int'($urandom_range(0, 16)) - 8;
        return c;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FIELD_BITS-1:0] nudge(logic [FIELD_BITS-1:0] v);
    int tol;
    int d;
    tol = int'(model_tol);
    case ($urandom_range(0, 19))
      16: d = tol;
      17: d = -tol;
      18: d = $urandom_range(0, 1) ? tol + 1 : -(tol + 1);
      19: return $urandom;
      default: d = int'($urandom_range(0, 2 * tol)) - tol;
    endcase
    return v + FIELD_BITS'(d);
  endfunction

  function automatic req_t flat_vertex(logic req, logic [ID_BITS-1:0] id,
                                       logic [FIELD_BITS-1:0] v);
    req_t r;
    r = '{req, id, v, v, v, v, v, v, v, v};
    return r;
  endfunction

  function automatic req_t rand_vertex(logic req);
    req_t r;
    r = '{req, ID_BITS'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    return r;
  endfunction

  function automatic req_t near_copy(req_t src, logic req);
    req_t r;
    r = '{req, ID_BITS'($urandom), nudge(src.pos_x), nudge(src.pos_y), nudge(src.pos_z),
          nudge(src.nrm_x), nudge(src.nrm_y), nudge(src.nrm_z), nudge(src.tex_u),
          nudge(src.tex_v)};
    return r;
  endfunction

  function automatic void push_req(req_t r);
    if (r.req_type == REQ_INSERT && made_vertices.size() < TBL_DEPTH)
      made_vertices = {made_vertices, r};
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic req_t pick_made();
    return made_vertices[$urandom_range(0, made_vertices.size() - 1)];
  endfunction

  function automatic void push_mix(int n, int ins_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < ins_pct) begin
        if (made_vertices.size() != 0 && $urandom_range(0, 3) == 0)
          push_req(near_copy(pick_made(), REQ_INSERT));
        else
          push_req(rand_vertex(REQ_INSERT));
      end else begin
        if (made_vertices.size() != 0 && $urandom_range(0, 9) < 7)
          push_req(near_copy(pick_made(), REQ_QUERY));
        else
          push_req(rand_vertex(REQ_QUERY));
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_rsp.size() != 0);
  endtask

  task automatic set_config(logic [STRIDE_W-1:0] stride, logic [TOL_W-1:0] tol);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LAYOUT_STRIDE;
    cfg_data  <= CFG_DATA_W'(stride);
    @(posedge clk);
    cfg_index <= REG_MATCH_TOL;
    cfg_data  <= CFG_DATA_W'(tol);
    @(posedge clk);
    cfg_we <= 1'b0;
    model_stride = stride;
    model_tol = tol;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_rsp = {expected_rsp, lookup_vertex(in_data)};
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          send_gap <= $urandom_range(0, send_idle_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output stall, started once on request
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : result_monitor
    rsp_t        want;
    int unsigned wait_n;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_rsp.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result %0d: unexpected transaction, status %0d index %h",
                     results_seen, out_data.status, out_data.match_index);
        end else begin
          want = expected_rsp.pop_front();
          if (out_data.status !== want.status || out_data.match_index !== want.match_index)
          begin
            fault_count++;
            if (fault_count <= 10)
              $display("result %0d: status %0d index %h, expected status %0d index %h",
                       results_seen, out_data.status, out_data.match_index,
                       want.status, want.match_index);
          end
        end
        wait_n = $urandom_range(0, recv_idle_max);
      end else begin
        wait_n = (recv_wait != 0) ? recv_wait - 1 : 0;
      end
      recv_wait <= wait_n;
      out_ready <= (wait_n == 0) && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    req_t        probe;
    longint      tol_plan[PHASES];
    int unsigned stride_plan[PHASES];
    logic [TOL_W-1:0] tol;
    stride_plan = '{8, 3, 5, 14, 15, 0, 6, 12, 13, 4, 16, 16};
    tol_plan = '{11, 0, 1048575, 11, 1000, TOL_PICK, 64, 0, 1048575, 11, TOL_PICK,
                 TOL_PICK};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset configuration: stride 8, tolerance 11
    push_req(flat_vertex(REQ_QUERY, 16'h0000, 32'h0));
    push_req(flat_vertex(REQ_INSERT, 16'h0000, 32'h0));
    push_req(flat_vertex(REQ_INSERT, 16'hFFFF, 32'h7FFF_FFFF));
    push_req(flat_vertex(REQ_INSERT, 16'h8001, 32'h8000_0000));
    probe = rand_vertex(REQ_INSERT);
    probe.vertex_index = 16'h1234;
    push_req(probe);
    probe.vertex_index = 16'h5678;
    probe.tex_u = probe.tex_u + 32'sd11;
    push_req(probe);
    push_req(flat_vertex(REQ_QUERY, 16'hFFFF, 32'h0));
    push_req(flat_vertex(REQ_QUERY, 16'h0000, 32'h7FFF_FFF4));
    push_req(flat_vertex(REQ_QUERY, 16'h0000, 32'h7FFF_FFF3));
    // most negative must not wrap onto the most positive entry
    push_req(flat_vertex(REQ_QUERY, 16'h0000, 32'h8000_0000));
    push_req(flat_vertex(REQ_QUERY, 16'h0000, 32'h8000_000B));
    push_req(flat_vertex(REQ_QUERY, 16'h0000, 32'hFFFF_FFFF));
    probe.req_type = REQ_QUERY;
    probe.tex_u = probe.tex_u + 32'sd11;
    push_req(probe);
    probe.tex_u = probe.tex_u - 32'sd22;
    push_req(probe);
    probe.nrm_y = probe.nrm_y + 32'sd12;
    push_req(probe);
    probe.nrm_y = probe.nrm_y - 32'sd12;
    probe.pos_z = probe.pos_z - 32'sd12;
    push_req(probe);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      tol = (tol_plan[p] == TOL_PICK) ? TOL_W'($urandom) : TOL_W'(tol_plan[p]);
      set_config((stride_plan[p] > 15) ? STRIDE_W'($urandom) : STRIDE_W'(stride_plan[p]),
                 tol);
      send_idle_max = (p == 0 || $urandom_range(0, 3) != 0) ? 15 : 0;
      recv_idle_max = (p == 0 || $urandom_range(0, 3) != 0) ? 15 : 0;
      push_mix(PHASE_ITEMS, 35);
      if (p == 4) begin
        // back-pressure: sender keeps offering while the output is held
        send_idle_max = 0;
        hold_req = 1'b1;
        push_mix(PHASE_ITEMS, 35);
      end
      wait_drained();
    end

    // back to back at the widest stride, starting on the newest vertex
    set_config(STRIDE_FULL, TOL_RESET);
    send_idle_max = 0;
    recv_idle_max = 0;
    probe = made_vertices[made_vertices.size() - 1];
    probe.req_type = REQ_QUERY;
    push_req(probe);
    push_mix(39, 20);
    wait_drained();

    set_config(4'd15, 20'hFFFFF);
    send_idle_max = 15;
    recv_idle_max = 15;
    push_mix(4, 0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_rsp.size() == 0)
      $display("vertex_duplicate_lookup_unit test passed");
    else
      $display("vertex_duplicate_lookup_unit test failed");
    $finish;
  end

  initial begin
    #(64'd8_000_000 * 2 * CLK_HALF);
    $display("vertex_duplicate_lookup_unit test failed");
    $finish;
  end

endmodule

/* files.f */
src/vdl_pkg.sv
src/vertex_duplicate_lookup_unit.sv
src/vdl_checker.sv
verif/tb_top.sv
